// ===== rtl/etns_pkg.sv =====
// Shared constants, command codes and stage types for the five-nearest search block.
`default_nettype none

package etns_pkg;

    localparam int FEATURE_LENGTH = 512;
    localparam int TOP_COUNT      = 5;

    localparam int QADDR_W = $clog2(FEATURE_LENGTH);
    localparam int IDX_W   = 9;
    localparam int VAL_W   = 16;
    localparam int ID_W    = 24;
    localparam int DIST_W  = 41;
    localparam int CNT_W   = 32;
    localparam int RANK_W  = 3;
    localparam int FILL_W  = $clog2(TOP_COUNT + 1);
    localparam int SQ_W    = 2 * VAL_W;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_CAND   = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_t;

    // closed candidate or finish token handed to the ranking stage
    typedef struct packed {
        logic              valid;
        logic              fin;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } offer_t;

endpackage

`default_nettype wire

// ===== rtl/etns_query_mem.sv =====
// Query vector store: one write port, one read port with registered read data.
`default_nettype none

module etns_query_mem (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [etns_pkg::QADDR_W-1:0] wr_addr,
    input  wire logic [etns_pkg::VAL_W-1:0]   wr_data,
    input  wire logic                        rd_en,
    input  wire logic [etns_pkg::QADDR_W-1:0] rd_addr,
    output logic      [etns_pkg::VAL_W-1:0]   rd_data
);
    import etns_pkg::*;

    logic [VAL_W-1:0] mem [FEATURE_LENGTH];
    logic [VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/etns_dist_pipe.sv =====
// Distance pipeline: query lookup, difference, square, saturating accumulate.
`default_nettype none

module etns_dist_pipe (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic                       adv,
    input  wire logic [1:0]                 cmd,
    input  wire logic [etns_pkg::IDX_W-1:0] element_index,
    input  wire logic [etns_pkg::VAL_W-1:0] element_value,
    input  wire logic [etns_pkg::ID_W-1:0]  candidate_id,
    input  wire logic                       last_element,
    output etns_pkg::offer_t                offer
);
    import etns_pkg::*;

    logic               in_range;
    logic [QADDR_W-1:0] q_addr;
    logic               q_wr_en;
    logic               q_rd_en;
    logic [VAL_W-1:0]   q_data;
    logic               take;

    // stage 1: query word arrives
    logic             s1_valid_reg;
    logic             s1_fin_reg;
    logic             s1_last_reg;
    logic             s1_in_range_reg;
    logic [ID_W-1:0]  s1_id_reg;
    logic [VAL_W-1:0] s1_val_reg;
    logic [VAL_W:0]   diff;
    logic [VAL_W:0]   diff_neg;
    logic [VAL_W-1:0] mag_next;

    // stage 2: square
    logic             s2_valid_reg;
    logic             s2_fin_reg;
    logic             s2_last_reg;
    logic [ID_W-1:0]  s2_id_reg;
    logic [VAL_W-1:0] s2_mag_reg;
    logic [SQ_W-1:0]  sq;

    // stage 3: accumulate
    logic              s3_valid_reg;
    logic              s3_fin_reg;
    logic              s3_last_reg;
    logic [ID_W-1:0]   s3_id_reg;
    logic [SQ_W-1:0]   s3_sq_reg;
    logic [DIST_W-1:0] acc_reg;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] sum_sat;

    offer_t offer_reg;

    assign in_range = (32'(element_index) < FEATURE_LENGTH);
    assign q_addr   = QADDR_W'(element_index);
    assign q_wr_en  = accept && (cmd == CMD_LOAD) && in_range;
    assign q_rd_en  = accept && (cmd == CMD_CAND);
    assign take     = accept && ((cmd == CMD_CAND) || (cmd == CMD_FINISH));

    etns_query_mem u_query_mem (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (q_addr),
        .wr_data (element_value),
        .rd_en   (q_rd_en),
        .rd_addr (q_addr),
        .rd_data (q_data)
    );

    assign diff     = {s1_val_reg[VAL_W-1], s1_val_reg} - {q_data[VAL_W-1], q_data};
    assign diff_neg = (VAL_W + 1)'(0) - diff;
    assign mag_next = !s1_in_range_reg ? '0 :
                      diff[VAL_W]      ? diff_neg[VAL_W-1:0] : diff[VAL_W-1:0];

    assign sq = SQ_W'(s2_mag_reg) * SQ_W'(s2_mag_reg);

    assign sum     = (DIST_W + 1)'(acc_reg) + (DIST_W + 1)'(s3_sq_reg);
    assign sum_sat = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            acc_reg      <= '0;
            offer_reg    <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            offer_reg.valid    <= s3_valid_reg && (s3_fin_reg || s3_last_reg);
            offer_reg.fin      <= s3_fin_reg;
            offer_reg.id       <= s3_id_reg;
            offer_reg.distance <= sum_sat;
            if (s3_valid_reg)
            begin
                // a closed candidate or a finish starts the next sum from zero
                acc_reg <= (s3_fin_reg || s3_last_reg) ? '0 : sum_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_fin_reg      <= (cmd == CMD_FINISH);
            s1_last_reg     <= last_element;
            s1_in_range_reg <= in_range;
            s1_id_reg       <= candidate_id;
            s1_val_reg      <= element_value;
            s2_fin_reg      <= s1_fin_reg;
            s2_last_reg     <= s1_last_reg;
            s2_id_reg       <= s1_id_reg;
            s2_mag_reg      <= mag_next;
            s3_fin_reg      <= s2_fin_reg;
            s3_last_reg     <= s2_last_reg;
            s3_id_reg       <= s2_id_reg;
            s3_sq_reg       <= sq;
        end
    end

    assign offer = offer_reg;

endmodule

`default_nettype wire

// ===== rtl/etns_top_list.sv =====
// Ranked nearest list with parallel insertion, candidate count and report buffer.
`default_nettype none

module etns_top_list (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  etns_pkg::offer_t                 offer,
    output logic                             adv,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [etns_pkg::RANK_W-1:0]      rank,
    output logic [etns_pkg::ID_W-1:0]        match_id,
    output logic [etns_pkg::DIST_W-1:0]      match_distance,
    output logic                             entry_valid,
    output logic [etns_pkg::CNT_W-1:0]       searched_total,
    output logic                             last_result
);
    import etns_pkg::*;

    logic [ID_W-1:0]   ids_reg       [TOP_COUNT];
    logic [DIST_W-1:0] dist_reg      [TOP_COUNT];
    logic [ID_W-1:0]   ids_next      [TOP_COUNT];
    logic [DIST_W-1:0] dist_next     [TOP_COUNT];
    logic [ID_W-1:0]   sh_ids        [TOP_COUNT];
    logic [DIST_W-1:0] sh_dist       [TOP_COUNT];
    logic [FILL_W-1:0] filled_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [ID_W-1:0]   snap_ids_reg  [TOP_COUNT];
    logic [DIST_W-1:0] snap_dist_reg [TOP_COUNT];
    logic [FILL_W-1:0] snap_filled_reg;
    logic [CNT_W-1:0]  snap_count_reg;
    logic              busy_reg;
    logic [RANK_W-1:0] rank_reg;

    logic [TOP_COUNT-1:0] ent_valid;
    logic [TOP_COUNT-1:0] keep;
    logic [TOP_COUNT:0]   keep_ext;
    logic                 full;
    logic                 enter;
    logic                 take;
    logic                 sorted_ok;

    assign adv  = !(offer.valid && offer.fin && busy_reg);
    assign take = offer.valid && adv;
    assign full = (filled_reg == FILL_W'(TOP_COUNT));
    assign enter = !full || (dist_reg[TOP_COUNT-1] > offer.distance);

    // keep marks the entries that stay ahead of the new key; it is a prefix
    always_comb
    begin
        for (int k = 0; k < TOP_COUNT; k++)
        begin
            ent_valid[k] = (32'(k) < 32'(filled_reg));
            keep[k] = ent_valid[k] &&
                      !((offer.distance < dist_reg[k]) ||
                        ((offer.distance == dist_reg[k]) && (offer.id < ids_reg[k])));
        end
        keep_ext   = {keep, 1'b1};
        sh_ids[0]  = offer.id;
        sh_dist[0] = offer.distance;
        for (int k = 1; k < TOP_COUNT; k++)
        begin
            sh_ids[k]  = ids_reg[k-1];
            sh_dist[k] = dist_reg[k-1];
        end
        for (int k = 0; k < TOP_COUNT; k++)
        begin
            if (keep[k])
            begin
                ids_next[k]  = ids_reg[k];
                dist_next[k] = dist_reg[k];
            end
            else if (keep_ext[k])
            begin
                ids_next[k]  = offer.id;
                dist_next[k] = offer.distance;
            end
            else
            begin
                ids_next[k]  = sh_ids[k];
                dist_next[k] = sh_dist[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            count_reg  <= '0;
            busy_reg   <= 1'b0;
            rank_reg   <= '0;
        end
        else
        begin
            if (take && offer.fin)
            begin
                filled_reg <= '0;
                count_reg  <= '0;
                busy_reg   <= 1'b1;
                rank_reg   <= '0;
            end
            else
            begin
                if (take)
                begin
                    if (enter && !full)
                    begin
                        filled_reg <= filled_reg + 1'b1;
                    end
                    if (count_reg != CNT_MAX)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                if (busy_reg && out_ready)
                begin
                    if (rank_reg == RANK_W'(TOP_COUNT - 1))
                    begin
                        busy_reg <= 1'b0;
                    end
                    else
                    begin
                        rank_reg <= rank_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && offer.fin)
        begin
            snap_ids_reg    <= ids_reg;
            snap_dist_reg   <= dist_reg;
            snap_filled_reg <= filled_reg;
            snap_count_reg  <= count_reg;
        end
        else if (take && enter)
        begin
            ids_reg  <= ids_next;
            dist_reg <= dist_next;
        end
    end

    assign out_valid      = busy_reg;
    assign rank           = rank_reg;
    assign entry_valid    = (32'(rank_reg) < 32'(snap_filled_reg));
    assign match_id       = entry_valid ? snap_ids_reg[rank_reg] : '0;
    assign match_distance = entry_valid ? snap_dist_reg[rank_reg] : '0;
    assign searched_total = snap_count_reg;
    assign last_result    = (rank_reg == RANK_W'(TOP_COUNT - 1));

    always_comb
    begin
        sorted_ok = 1'b1;
        for (int k = 1; k < TOP_COUNT; k++)
        begin
            if (ent_valid[k] &&
                ((dist_reg[k] < dist_reg[k-1]) ||
                 ((dist_reg[k] == dist_reg[k-1]) && (ids_reg[k] < ids_reg[k-1]))))
            begin
                sorted_ok = 1'b0;
            end
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(filled_reg) <= TOP_COUNT)
        else $error("list fill count beyond capacity");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (32'(rank_reg) < TOP_COUNT))
        else $error("report rank beyond list");

    a_list_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_ok)
        else $error("nearest list out of order");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && offer.fin) |=> (busy_reg && (rank_reg == '0) &&
                                 (filled_reg == '0) && (count_reg == '0)))
        else $error("finish did not start report and clear search");

    a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_ready && last_result) |=> !busy_reg)
        else $error("report did not end after final rank");

endmodule

`default_nettype wire

// ===== rtl/euclidean_top5_nearest_search_top.sv =====
// Top level of the five-nearest squared-distance search block.
`default_nettype none

// Load the query with load requests, stream candidate elements (last_element
// closes a candidate, whose id comes from that request), then send finish to
// get five results, rank 0 first, and clear the search; the query is kept.
// One request is accepted per cycle while in_ready is high. Candidate
// elements pass a four-stage pipeline (query memory read, difference,
// square, accumulate) before the ranking stage, which inserts a closed
// candidate with parallel compares. A finish hands the list to a report
// buffer that drains one result per accepted output cycle; a second finish
// that reaches the ranking stage while that report is still draining holds
// the input until the buffer is free. No clearing pass after reset: query
// entries are meaningful only once written.
module euclidean_top5_nearest_search_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  cmd,
    input  wire logic [etns_pkg::IDX_W-1:0]  element_index,
    input  wire logic [etns_pkg::VAL_W-1:0]  element_value,
    input  wire logic [etns_pkg::ID_W-1:0]   candidate_id,
    input  wire logic                        last_element,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [etns_pkg::RANK_W-1:0]      rank,
    output logic [etns_pkg::ID_W-1:0]        match_id,
    output logic [etns_pkg::DIST_W-1:0]      match_distance,
    output logic                             entry_valid,
    output logic [etns_pkg::CNT_W-1:0]       searched_total,
    output logic                             last_result
);
    import etns_pkg::*;

    offer_t offer;
    logic   adv;
    logic   accept;

    assign in_ready = adv;
    assign accept   = in_valid && adv;

    etns_dist_pipe u_dist_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .adv           (adv),
        .cmd           (cmd),
        .element_index (element_index),
        .element_value (element_value),
        .candidate_id  (candidate_id),
        .last_element  (last_element),
        .offer         (offer)
    );

    etns_top_list u_top_list (
        .clk            (clk),
        .rst_n          (rst_n),
        .offer          (offer),
        .adv            (adv),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rank           (rank),
        .match_id       (match_id),
        .match_distance (match_distance),
        .entry_valid    (entry_valid),
        .searched_total (searched_total),
        .last_result    (last_result)
    );

endmodule

`default_nettype wire
